### src/udp_segmentation_frame_builder_assert.svh
// Assertion macros shared by the frame builder modules.
// Needs a clock named clk and an active-low reset named arst_n in scope.
`ifndef UDP_SEGMENTATION_FRAME_BUILDER_ASSERT_SVH
`define UDP_SEGMENTATION_FRAME_BUILDER_ASSERT_SVH

// same-cycle implication
`define UFB_ASSERT_IMP(label, cond, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define UFB_ASSERT_NXT(label, cond, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (cons)) \
		else $error(msg);

`endif

### src/ufb_pkg.sv
// Types and constants of the UDP segmentation frame builder.
// No dependencies.
package ufb_pkg;

	localparam int HDR_ETH = 14;
	localparam int HDR_IP  = 20;
	localparam int HDR_UDP = 8;
	localparam int HDR_ALL = HDR_ETH + HDR_IP + HDR_UDP;

	localparam logic [15:0] IP_VER_IHL_TOS = 16'h4500;
	localparam logic [15:0] IP_TTL_PROTO   = 16'h4011;

	typedef enum logic [1:0] {
		STATUS_OK       = 2'd0,
		STATUS_INVALID  = 2'd1,
		STATUS_NO_FRAME = 2'd2,
		STATUS_TOO_MANY = 2'd3
	} status_t;

	typedef struct packed {
		status_t     status;
		logic [22:0] frame_address;
		logic [11:0] frame_length;
		logic [15:0] payload_offset;
		logic [10:0] ip_total_length;
		logic [15:0] ip_header_checksum;
		logic [10:0] udp_length;
		logic [15:0] bytes_so_far;
		logic        last;
	} result_t;

	typedef struct packed {
		logic        take;
		logic        complete;
		logic [12:0] done;
	} pool_req_t;

	typedef struct packed {
		logic        empty;
		logic        one_left;
		logic [22:0] frame_address;
	} pool_stat_t;

endpackage

### src/udp_segmentation_frame_builder.sv
// A request is not accepted until the previous one is done. It passes through
// ST_SUM (header sum and checks) and ST_CHECK (fold and error choice), then
// gives one descriptor per cycle, while the output is not stalled, from the
// shared remainder unit. An error gives one error beat; a completion, none.
// Reset: free frames = pool size, slot 0, frame address at the pool base,
// source_ip 0, no beat pending.
module udp_segmentation_frame_builder #(
	parameter int TOTAL_FRAMES    = 4096,
	parameter int FRAME_BYTES     = 2048,
	parameter int RESERVED_FRAMES = 256,
	parameter int MAX_SEGMENTS    = 64
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [31:0]  cfg_data,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// dest_ip, datagram_bytes, segment_bytes, completed_frames
	input  logic [71:0]  s_axis_tdata,
	// command
	input  logic         s_axis_tuser,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// frame_address, frame_length, payload_offset, ip_total_length,
	// ip_header_checksum, udp_length, bytes_so_far, zero pad
	output logic [111:0] m_axis_tdata,
	// status
	output logic [1:0]   m_axis_tuser,
	output logic         m_axis_tlast
);
	import ufb_pkg::*;

	logic [31:0] source_ip_q;
	pool_req_t   pool_req;
	pool_stat_t  pool_stat;
	result_t     res;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			source_ip_q <= '0;
		end else if (cfg_valid) begin
			source_ip_q <= cfg_data;
		end
	end

	ufb_pool #(
		.TOTAL_FRAMES    (TOTAL_FRAMES),
		.FRAME_BYTES     (FRAME_BYTES),
		.RESERVED_FRAMES (RESERVED_FRAMES)
	) u_pool (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (pool_req),
		.stat   (pool_stat)
	);

	ufb_sequencer #(
		.FRAME_BYTES  (FRAME_BYTES),
		.MAX_SEGMENTS (MAX_SEGMENTS)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_cmd    (s_axis_tuser),
		.in_dst    (s_axis_tdata[31:0]),
		.in_total  (s_axis_tdata[47:32]),
		.in_seg    (s_axis_tdata[58:48]),
		.in_done   (s_axis_tdata[71:59]),
		.source_ip (source_ip_q),
		.pool_req  (pool_req),
		.pool_stat (pool_stat),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_res   (res)
	);

	assign m_axis_tdata = {7'b0, res.bytes_so_far, res.udp_length, res.ip_header_checksum,
		res.ip_total_length, res.payload_offset, res.frame_length, res.frame_address};
	assign m_axis_tuser = res.status;
	assign m_axis_tlast = res.last;

endmodule

### src/ufb_pool.sv
// Frame pool: free frame count, wrapping slot index and frame address.
// Depends on ufb_pkg and the assertion header.
module ufb_pool #(
	parameter int TOTAL_FRAMES    = 4096,
	parameter int FRAME_BYTES     = 2048,
	parameter int RESERVED_FRAMES = 256
) (
	input  logic               clk,
	input  logic               arst_n,
	input  ufb_pkg::pool_req_t req,
	output ufb_pkg::pool_stat_t stat
);
	import ufb_pkg::*;
	`include "udp_segmentation_frame_builder_assert.svh"

	localparam int FRAME_POOL = (TOTAL_FRAMES > RESERVED_FRAMES) ?
		(TOTAL_FRAMES - RESERVED_FRAMES) : 0;
	localparam int FREE_W = (FRAME_POOL < 2) ? 1 : $clog2(FRAME_POOL + 1);
	localparam int SLOT_W = (FRAME_POOL < 2) ? 1 : $clog2(FRAME_POOL);
	localparam int SUM_W = ((FREE_W > 13) ? FREE_W : 13) + 1;
	localparam logic [22:0] ADDR_BASE = 23'((RESERVED_FRAMES * FRAME_BYTES) % (1 << 23));
	localparam logic [22:0] ADDR_STEP = 23'(FRAME_BYTES);

	logic [FREE_W-1:0] free_q;
	logic [SLOT_W-1:0] slot_q;
	logic [22:0]       addr_q;
	logic [SUM_W-1:0]  sum;
	logic [SLOT_W:0]   slot_inc;
	logic              slot_wrap;

	assign sum       = SUM_W'(free_q) + SUM_W'(req.done);
	assign slot_inc  = {1'b0, slot_q} + (SLOT_W+1)'(1);
	assign slot_wrap = slot_inc >= (SLOT_W+1)'(FRAME_POOL);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_q <= FREE_W'(FRAME_POOL);
			slot_q <= '0;
			addr_q <= ADDR_BASE;
		end else if (req.complete) begin
			free_q <= (sum > SUM_W'(FRAME_POOL)) ? FREE_W'(FRAME_POOL) : sum[FREE_W-1:0];
		end else if (req.take) begin
			free_q <= free_q - FREE_W'(1);
			if (slot_wrap) begin
				slot_q <= '0;
				addr_q <= ADDR_BASE;
			end else begin
				slot_q <= slot_inc[SLOT_W-1:0];
				addr_q <= addr_q + ADDR_STEP;
			end
		end
	end

	assign stat.empty         = (free_q == '0);
	assign stat.one_left      = (free_q == FREE_W'(1));
	assign stat.frame_address = addr_q;

	`UFB_ASSERT_IMP(a_take_not_empty, req.take, free_q != '0, "frame taken from empty pool")
	`UFB_ASSERT_IMP(a_free_bounded, 1'b1, SUM_W'(free_q) <= SUM_W'(FRAME_POOL),
		"free frame count above pool size")
	`UFB_ASSERT_NXT(a_take_dec, req.take && !req.complete,
		free_q == $past(free_q) - FREE_W'(1), "free count not decremented on take")

endmodule

### src/ufb_sequencer.sv
// Request sequencer: checks a request then emits one descriptor per cycle unless
// stalled, via a shared subtract and compare unit. Uses ufb_pkg and the header.
module ufb_sequencer #(
	parameter int FRAME_BYTES  = 2048,
	parameter int MAX_SEGMENTS = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                in_cmd,
	input  logic [31:0]         in_dst,
	input  logic [15:0]         in_total,
	input  logic [10:0]         in_seg,
	input  logic [12:0]         in_done,
	input  logic [31:0]         source_ip,
	output ufb_pkg::pool_req_t  pool_req,
	input  ufb_pkg::pool_stat_t pool_stat,
	output logic                out_valid,
	input  logic                out_ready,
	output ufb_pkg::result_t    out_res
);
	import ufb_pkg::*;
	`include "udp_segmentation_frame_builder_assert.svh"

	localparam int MS_W   = $clog2(MAX_SEGMENTS + 1);
	localparam int PROD_W = 11 + MS_W;
	localparam int CMP_W  = (PROD_W > 16) ? PROD_W : 16;

	typedef enum logic [1:0] {ST_IDLE, ST_SUM, ST_CHECK, ST_EMIT} state_t;

	state_t      state_q;
	logic        cmd_q;
	logic [31:0] dst_q;
	logic [15:0] total_q;
	logic [10:0] seg_q;
	logic [12:0] done_q;
	logic [18:0] sum_q;
	logic        invalid_q;
	logic        too_many_q;
	logic [15:0] fold_q;
	logic [15:0] off_q;
	logic        out_valid_q;
	result_t     out_q;

	logic        can_load;
	logic [16:0] fold1;
	logic [16:0] fold2;
	logic [15:0] rem;
	logic        is_last;
	logic [10:0] len;
	logic [11:0] tot;
	logic [16:0] ck_s1;
	logic [16:0] ck_s2;
	logic [15:0] sofar;
	logic        fin;
	result_t     seg_res;
	result_t     err_res;
	status_t     err_status;
	logic        err_hit;

	assign can_load = !out_valid_q || out_ready;
	assign in_ready = (state_q == ST_IDLE);

	assign fold1 = 17'(sum_q[15:0]) + 17'(sum_q[18:16]);
	assign fold2 = 17'(fold1[15:0]) + 17'(fold1[16]);

	// shared unit: remaining bytes and last-segment compare
	assign rem     = total_q - off_q;
	assign is_last = (rem <= 16'(seg_q));
	assign len     = is_last ? rem[10:0] : seg_q;
	assign tot     = 12'(len) + 12'(HDR_IP + HDR_UDP);
	assign ck_s1   = 17'(fold_q) + 17'(tot);
	assign ck_s2   = 17'(ck_s1[15:0]) + 17'(ck_s1[16]);
	assign sofar   = off_q + 16'(len);
	assign fin     = is_last || pool_stat.one_left;

	always_comb begin
		seg_res                    = '0;
		seg_res.status             = STATUS_OK;
		seg_res.frame_address      = pool_stat.frame_address;
		seg_res.frame_length       = 12'(len) + 12'(HDR_ALL);
		seg_res.payload_offset     = off_q;
		seg_res.ip_total_length    = tot[10:0];
		seg_res.ip_header_checksum = ~ck_s2[15:0];
		seg_res.udp_length         = 11'(12'(len) + 12'(HDR_UDP));
		seg_res.bytes_so_far       = sofar;
		seg_res.last               = fin;
	end

	always_comb begin
		err_hit    = 1'b1;
		err_status = STATUS_INVALID;
		if (invalid_q) begin
			err_status = STATUS_INVALID;
		end else if (too_many_q) begin
			err_status = STATUS_TOO_MANY;
		end else if (pool_stat.empty) begin
			err_status = STATUS_NO_FRAME;
		end else begin
			err_hit = 1'b0;
		end
		err_res        = '0;
		err_res.status = err_status;
		err_res.last   = 1'b1;
	end

	always_comb begin
		pool_req          = '0;
		pool_req.done     = done_q;
		pool_req.complete = (state_q == ST_SUM) && cmd_q;
		pool_req.take     = (state_q == ST_EMIT) && can_load;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cmd_q       <= 1'b0;
			dst_q       <= '0;
			total_q     <= '0;
			seg_q       <= '0;
			done_q      <= '0;
			sum_q       <= '0;
			invalid_q   <= 1'b0;
			too_many_q  <= 1'b0;
			fold_q      <= '0;
			off_q       <= '0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						cmd_q   <= in_cmd;
						dst_q   <= in_dst;
						total_q <= in_total;
						seg_q   <= in_seg;
						done_q  <= in_done;
						state_q <= ST_SUM;
					end
				end
				ST_SUM: begin
					sum_q <= 19'(IP_VER_IHL_TOS) + 19'(IP_TTL_PROTO)
						+ 19'(source_ip[31:16]) + 19'(source_ip[15:0])
						+ 19'(dst_q[31:16]) + 19'(dst_q[15:0]);
					invalid_q <= (total_q == '0) || (seg_q == '0)
						|| (13'(seg_q) + 13'(HDR_ALL) > 13'(FRAME_BYTES));
					too_many_q <= CMP_W'(total_q)
						> CMP_W'(PROD_W'(MAX_SEGMENTS) * PROD_W'(seg_q));
					state_q <= cmd_q ? ST_IDLE : ST_CHECK;
				end
				ST_CHECK: begin
					fold_q <= fold2[15:0];
					off_q  <= '0;
					if (!err_hit) begin
						state_q <= ST_EMIT;
					end else if (can_load) begin
						out_q       <= err_res;
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				ST_EMIT: begin
					if (can_load) begin
						out_q       <= seg_res;
						out_valid_q <= 1'b1;
						off_q       <= sofar;
						if (fin) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_res   = out_q;

	`UFB_ASSERT_IMP(a_emit_has_frame, state_q == ST_EMIT, !pool_stat.empty,
		"emitting with no free frame")
	`UFB_ASSERT_IMP(a_error_is_last, out_valid_q && (out_q.status != STATUS_OK),
		out_q.last, "error result without last")
	`UFB_ASSERT_IMP(a_mid_run, out_valid_q && !out_q.last, state_q == ST_EMIT,
		"non-final descriptor while not emitting")
	`UFB_ASSERT_IMP(a_progress, out_valid_q && (out_q.status == STATUS_OK),
		out_q.bytes_so_far > out_q.payload_offset, "descriptor with empty payload")

endmodule

### verif/tb_udp_segmentation_frame_builder.sv
// Self-checking testbench of udp_segmentation_frame_builder: segments requests, predicts
// every descriptor and compares each output beat field by field with the oldest prediction.
// Depends on ufb_pkg and the RTL top level only.
`timescale 1ns / 1ps

module tb_udp_segmentation_frame_builder;
	import ufb_pkg::*;

	localparam int TOTAL_FRAMES    = 4096;
	localparam int FRAME_BYTES     = 2048;
	localparam int RESERVED_FRAMES = 256;
	localparam int MAX_SEGMENTS    = 64;
	localparam int unsigned POOL_FRAMES = TOTAL_FRAMES - RESERVED_FRAMES;
	localparam int SETTLE_CYCLES  = 12;
	localparam int HOLD_CYCLES    = 400;
	localparam int RANDOM_ITEMS   = 370;
	localparam longint CYCLE_LIMIT = 2000000;

	localparam logic CMD_SEND     = 1'b0;
	localparam logic CMD_COMPLETE = 1'b1;

	logic         clk;
	logic         arst_n;
	logic         cfg_valid;
	logic         cfg_ready;
	logic [31:0]  cfg_data;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [71:0]  s_axis_tdata;
	logic         s_axis_tuser;
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [111:0] m_axis_tdata;
	logic [1:0]   m_axis_tuser;
	logic         m_axis_tlast;

	result_t      expected_descriptors[$];
	int unsigned  model_free;
	int unsigned  model_slot;
	logic [31:0]  model_source_ip;
	int           errors;
	longint       cycle_count;
	bit           no_idle;
	bit           hold_pending;

	udp_segmentation_frame_builder #(
		.TOTAL_FRAMES(TOTAL_FRAMES),
		.FRAME_BYTES(FRAME_BYTES),
		.RESERVED_FRAMES(RESERVED_FRAMES),
		.MAX_SEGMENTS(MAX_SEGMENTS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("[udp_segmentation_frame_builder] ERROR");
			$finish;
		end
	end

	function automatic void predict_descriptors(logic cmd, logic [31:0] dst,
			logic [15:0] dgram_in, logic [10:0] seg_in, logic [12:0] done_in);
		int unsigned dgram, seg, nseg, off, len, tot, hdr_sum, base, s, sofar, f;
		result_t r;
		dgram = dgram_in;
		seg = seg_in;
		if (cmd == CMD_COMPLETE) begin
			f = model_free + done_in;
			model_free = (f > POOL_FRAMES) ? POOL_FRAMES : f;
			return;
		end
		r = '0;
		r.last = 1'b1;
		if (dgram == 0 || seg == 0 || seg + HDR_ALL > FRAME_BYTES) begin
			r.status = STATUS_INVALID;
			expected_descriptors.push_back(r);
			return;
		end
		nseg = (dgram + seg - 1) / seg;
		if (nseg > MAX_SEGMENTS) begin
			r.status = STATUS_TOO_MANY;
			expected_descriptors.push_back(r);
			return;
		end
		if (model_free == 0 || POOL_FRAMES == 0) begin
			r.status = STATUS_NO_FRAME;
			expected_descriptors.push_back(r);
			return;
		end
		// header sum with total length and checksum zero
		hdr_sum = IP_VER_IHL_TOS + IP_TTL_PROTO + model_source_ip[31:16]
			+ model_source_ip[15:0] + dst[31:16] + dst[15:0];
		hdr_sum = (hdr_sum & 32'hFFFF) + (hdr_sum >> 16);
		hdr_sum = (hdr_sum & 32'hFFFF) + (hdr_sum >> 16);
		base = ~hdr_sum & 32'hFFFF;
		sofar = 0;
		for (int unsigned i = 0; i < nseg; i++) begin
			if (model_free == 0)
				break;
			off = i * seg;
			len = (i + 1 < nseg) ? seg : dgram - off;
			tot = HDR_IP + HDR_UDP + len;
			model_free--;
			r.status = STATUS_OK;
			r.frame_address = 23'((RESERVED_FRAMES + model_slot) * FRAME_BYTES);
			model_slot = (model_slot + 1 >= POOL_FRAMES) ? 0 : model_slot + 1;
			s = (~base & 32'hFFFF) + tot;
			s = (s + (s >> 16)) & 32'hFFFF;
			sofar += len;
			r.frame_length = 12'(HDR_ETH + tot);
			r.payload_offset = 16'(off);
			r.ip_total_length = 11'(tot);
			r.ip_header_checksum = 16'(~s & 32'hFFFF);
			r.udp_length = 11'(HDR_UDP + len);
			r.bytes_so_far = 16'(sofar);
			r.last = (i + 1 == nseg) || (model_free == 0);
			expected_descriptors.push_back(r);
			if (r.last)
				break;
		end
	endfunction

	function automatic void check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			errors++;
		end
	endfunction

	always @(posedge clk) begin
		result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_descriptors.size() == 0) begin
				$display("%0t: unexpected beat, expected none, actual tdata %h tuser %h tlast %b",
					$time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
				errors++;
			end else begin
				want = expected_descriptors.pop_front();
				check_field("status", want.status, m_axis_tuser);
				check_field("frame_address", want.frame_address, m_axis_tdata[22:0]);
				check_field("frame_length", want.frame_length, m_axis_tdata[34:23]);
				check_field("payload_offset", want.payload_offset, m_axis_tdata[50:35]);
				check_field("ip_total_length", want.ip_total_length, m_axis_tdata[61:51]);
				check_field("ip_header_checksum", want.ip_header_checksum,
					m_axis_tdata[77:62]);
				check_field("udp_length", want.udp_length, m_axis_tdata[88:78]);
				check_field("bytes_so_far", want.bytes_so_far, m_axis_tdata[104:89]);
				check_field("pad", 0, m_axis_tdata[111:105]);
				check_field("last", want.last, m_axis_tlast);
			end
		end
	end

	// output sink: random stall per beat, one long hold-off on request
	initial begin
		int gap;
		m_axis_tready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			gap = no_idle ? 0 : $urandom_range(0, 8);
			if (hold_pending) begin
				hold_pending = 1'b0;
				gap = HOLD_CYCLES;
			end
			if (gap > 0) begin
				m_axis_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
		end
	end

	task automatic offer_request(logic cmd, logic [31:0] dst, logic [15:0] dgram,
			logic [10:0] seg, logic [12:0] done);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 8);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {done, seg, dgram, dst};
		s_axis_tuser <= cmd;
		do @(posedge clk); while (!s_axis_tready);
		predict_descriptors(cmd, dst, dgram, seg, done);
	endtask

	task automatic send_datagram(logic [15:0] dgram, logic [10:0] seg);
		offer_request(CMD_SEND, $urandom, dgram, seg, 13'($urandom_range(0, 4096)));
	endtask

	task automatic return_frames(logic [12:0] done);
		offer_request(CMD_COMPLETE, $urandom, 16'($urandom), 11'($urandom_range(0, 2006)),
			done);
	endtask

	task automatic wait_quiet();
		s_axis_tvalid <= 1'b0;
		while (expected_descriptors.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_source_ip(logic [31:0] value);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		model_source_ip = value;
	endtask

	task automatic test_reset_defaults();
		offer_request(CMD_SEND, 32'h0000_0000, 16'd1, 11'd1, 13'd0);
		offer_request(CMD_SEND, 32'hFFFF_FFFF, 16'd65535, 11'd1024, 13'd4096);
		wait_quiet();
	endtask

	task automatic test_invalid_requests();
		send_datagram(16'd0, 11'd100);
		send_datagram(16'd100, 11'd0);
		send_datagram(16'd2007, 11'd2007);
		send_datagram(16'd2047, 11'd2047);
		send_datagram(16'd65535, 11'd1);
		send_datagram(16'd65, 11'd1);
		send_datagram(16'd64001, 11'd1000);
		wait_quiet();
	endtask

	task automatic test_segment_edges();
		send_datagram(16'd2006, 11'd2006);
		send_datagram(16'd65535, 11'd2006);
		send_datagram(16'd64, 11'd1);
		send_datagram(16'd10, 11'd2006);
		send_datagram(16'd1500, 11'd1499);
		wait_quiet();
	endtask

	task automatic test_checksum_extremes();
		write_source_ip(32'hFFFF_FFFF);
		offer_request(CMD_SEND, 32'hFFFF_FFFF, 16'd3000, 11'd1000, 13'd0);
		offer_request(CMD_SEND, 32'h0000_0000, 16'd700, 11'd700, 13'd0);
		wait_quiet();
		write_source_ip(32'h0000_0001);
		offer_request(CMD_SEND, 32'hFFFF_FFFE, 16'd2000, 11'd999, 13'd0);
		wait_quiet();
		write_source_ip($urandom);
	endtask

	task automatic test_completion();
		return_frames(13'd0);
		return_frames(13'd4096);
		send_datagram(16'd300, 11'd100);
		return_frames(13'd2);
		wait_quiet();
	endtask

	task automatic test_pool_exhaustion();
		if (model_free % MAX_SEGMENTS == 0)
			send_datagram(16'd5, 11'd5);
		// 64-segment requests until the pool runs dry mid-request
		while (model_free > 0)
			send_datagram(16'd64000, 11'd1000);
		send_datagram(16'd300, 11'd100);
		send_datagram(16'd0, 11'd100);
		send_datagram(16'd65535, 11'd1);
		return_frames(13'd1);
		send_datagram(16'd300, 11'd100);
		send_datagram(16'd300, 11'd100);
		return_frames(13'd4096);
		return_frames(13'd4096);
		wait_quiet();
	endtask

	task automatic test_backpressure();
		no_idle = 1'b1;
		hold_pending = 1'b1;
		repeat (10) send_datagram(16'd8000, 11'd1000);
		wait_quiet();
		no_idle = 1'b0;
	endtask

	task automatic test_random();
		int unsigned k, segmax, seg, dgram, pick;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 100 == 99) begin
				wait_quiet();
				case ($urandom_range(0, 3))
					0: write_source_ip(32'h0000_0000);
					1: write_source_ip(32'hFFFF_FFFF);
					default: write_source_ip($urandom);
				endcase
			end
			if (n % 60 == 0)
				no_idle = ($urandom_range(0, 2) == 0);
			pick = $urandom_range(0, 99);
			if (pick < 15) begin
				if ($urandom_range(0, 9) == 0)
					return_frames(13'd4096);
				else
					return_frames(13'($urandom_range(0, 64)));
			end else if (pick < 25) begin
				send_datagram(16'($urandom_range(0, 65535)), 11'($urandom_range(0, 2006)));
			end else begin
				k = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 64) : $urandom_range(1, 8);
				segmax = 65535 / k;
				if (segmax > 2006)
					segmax = 2006;
				seg = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 64)
					: $urandom_range(1, segmax);
				dgram = $urandom_range((k - 1) * seg + 1, k * seg);
				send_datagram(16'(dgram), 11'(seg));
			end
		end
		wait_quiet();
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = 1'b0;
		errors = 0;
		cycle_count = 0;
		no_idle = 1'b0;
		hold_pending = 1'b0;
		model_free = POOL_FRAMES;
		model_slot = 0;
		model_source_ip = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		test_reset_defaults();
		test_invalid_requests();
		test_segment_edges();
		test_checksum_extremes();
		test_completion();
		test_pool_exhaustion();
		test_backpressure();
		test_random();
		if (errors == 0 && expected_descriptors.size() == 0) begin
			$display("[udp_segmentation_frame_builder] OK");
		end else begin
			$display("[udp_segmentation_frame_builder] ERROR");
		end
		$finish;
	end

endmodule
